// File: sv/command_source_arbiter_defines.svh
// ----------------------------------------------------------------------------
// Command source arbiter assertion macros
// Shared concurrent assertion forms used by the arbiter modules.
// ----------------------------------------------------------------------------
`ifndef COMMAND_SOURCE_ARBITER_DEFINES_SVH
`define COMMAND_SOURCE_ARBITER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CSA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/csa_pkg.sv
// ----------------------------------------------------------------------------
// Command source arbiter package
// Types, codes and reset values shared by the arbiter modules.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int AGE_BITS_DEF = 16;
  localparam int CFG_W        = 16;
  localparam int CMD_W        = 64;
  localparam int PORT_W       = 2;
  localparam int OP_W         = 3;
  localparam int IDX_W        = 2;
  localparam int Q_DEPTH      = 8;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);

  localparam logic [CFG_W-1:0] OVERRIDE_RST = 16'd1000;
  localparam logic [CFG_W-1:0] FAILSAFE_RST = 16'd500;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd100;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_MODE   = 3'd1,
    OP_STOP   = 3'd2,
    OP_MANUAL = 3'd3,
    OP_AUTO   = 3'd4
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_OVERRIDE = 2'd0,
    REG_FAILSAFE = 2'd1,
    REG_HOLD     = 2'd2,
    REG_PERIOD   = 2'd3
  } reg_idx_t;

  localparam logic [PORT_W-1:0] PORT_DRIVE = 2'd0;
  localparam logic [PORT_W-1:0] PORT_STOP  = 2'd3;
  localparam logic [PORT_W-1:0] CH_INVALID = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [PORT_W-1:0] channel;
    logic              auto_on;
    logic [CMD_W-1:0]  payload;
  } item_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [CMD_W-1:0]  command;
    logic              last;
  } res_t;

  // The second result is only ever pushed together with the first.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// File: sv/csa_core.sv
// ----------------------------------------------------------------------------
// Command source arbiter decision core
// Holds the configuration and the mode and age state, and turns one
// registered item per cycle into zero, one or two results.
// ----------------------------------------------------------------------------
`include "command_source_arbiter_defines.svh"

module csa_core #(
  parameter int AGE_BITS = csa_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [csa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [csa_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        item_valid,
  input  csa_pkg::item_t              item,
  output csa_pkg::push_t              push
);
  import csa_pkg::*;

  localparam int CMP_W = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  logic [CFG_W-1:0]    override_ticks;
  logic [CFG_W-1:0]    failsafe_ticks;
  logic [CFG_W-1:0]    stop_hold_ticks;
  logic [CFG_W-1:0]    check_period_ticks;

  logic                auto_enabled, auto_enabled_next;
  logic                stop_seen, stop_seen_next;
  logic [AGE_BITS-1:0] stop_age, stop_age_next;
  logic                manual_seen, manual_seen_next;
  logic [AGE_BITS-1:0] manual_age, manual_age_next;
  logic                valid_seen, valid_seen_next;
  logic [AGE_BITS-1:0] valid_age, valid_age_next;
  logic [CFG_W-1:0]    check_phase, check_phase_next;

  logic [AGE_BITS-1:0] stop_age_inc, manual_age_inc, valid_age_inc;
  logic [CFG_W-1:0]    phase_inc;
  logic                hold_active, override_active, stale;

  assign stop_age_inc   = (stop_age == AGE_MAX) ? stop_age : stop_age + 1'b1;
  assign manual_age_inc = (manual_age == AGE_MAX) ? manual_age : manual_age + 1'b1;
  assign valid_age_inc  = (valid_age == AGE_MAX) ? valid_age : valid_age + 1'b1;
  assign phase_inc      = check_phase + 1'b1;

  assign hold_active     = stop_seen && (CMP_W'(stop_age) < CMP_W'(stop_hold_ticks));
  assign override_active = manual_seen && (CMP_W'(manual_age) < CMP_W'(override_ticks));
  assign stale           = valid_seen && (CMP_W'(valid_age_inc) > CMP_W'(failsafe_ticks));

  always_ff @(posedge clk) begin
    if (rst) begin
      override_ticks     <= OVERRIDE_RST;
      failsafe_ticks     <= FAILSAFE_RST;
      stop_hold_ticks    <= HOLD_RST;
      check_period_ticks <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_OVERRIDE: override_ticks     <= cfg_data;
        REG_FAILSAFE: failsafe_ticks     <= cfg_data;
        REG_HOLD:     stop_hold_ticks    <= cfg_data;
        REG_PERIOD:   check_period_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    auto_enabled_next = auto_enabled;
    stop_seen_next    = stop_seen;
    stop_age_next     = stop_age;
    manual_seen_next  = manual_seen;
    manual_age_next   = manual_age;
    valid_seen_next   = valid_seen;
    valid_age_next    = valid_age;
    check_phase_next  = check_phase;
    push              = '0;
    if (item_valid) begin
      unique case (op_t'(item.opcode))
        OP_TICK: begin
          if (stop_seen) stop_age_next = stop_age_inc;
          if (manual_seen) manual_age_next = manual_age_inc;
          if (valid_seen) valid_age_next = valid_age_inc;
          if (phase_inc >= check_period_ticks) begin
            check_phase_next = '0;
            if (stale) begin
              push.v0 = 1'b1;
              push.r0 = '{port: PORT_DRIVE, command: '0, last: 1'b1};
            end
          end else begin
            check_phase_next = phase_inc;
          end
        end
        OP_MODE: begin
          auto_enabled_next = item.auto_on;
        end
        OP_STOP: begin
          stop_seen_next = 1'b1;
          stop_age_next  = '0;
          push.v0 = 1'b1;
          push.r0 = '{port: PORT_STOP, command: item.payload, last: 1'b0};
          push.v1 = 1'b1;
          push.r1 = '{port: PORT_DRIVE, command: '0, last: 1'b1};
        end
        OP_MANUAL: begin
          if (item.channel != CH_INVALID) begin
            manual_seen_next = 1'b1;
            manual_age_next  = '0;
            valid_seen_next  = 1'b1;
            valid_age_next   = '0;
            if (!hold_active) begin
              push.v0 = 1'b1;
              push.r0 = '{port: item.channel, command: item.payload, last: 1'b1};
            end
          end
        end
        OP_AUTO: begin
          if (item.channel != CH_INVALID && auto_enabled && !hold_active &&
              !override_active) begin
            valid_seen_next = 1'b1;
            valid_age_next  = '0;
            push.v0 = 1'b1;
            push.r0 = '{port: item.channel, command: item.payload, last: 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enabled <= 1'b0;
      stop_seen    <= 1'b0;
      stop_age     <= '0;
      manual_seen  <= 1'b0;
      manual_age   <= '0;
      valid_seen   <= 1'b0;
      valid_age    <= '0;
      check_phase  <= '0;
    end else begin
      auto_enabled <= auto_enabled_next;
      stop_seen    <= stop_seen_next;
      stop_age     <= stop_age_next;
      manual_seen  <= manual_seen_next;
      manual_age   <= manual_age_next;
      valid_seen   <= valid_seen_next;
      valid_age    <= valid_age_next;
      check_phase  <= check_phase_next;
    end
  end

  `CSA_ASSERT(a_pair_order, push.v1 |-> push.v0, "second result without a first")
  `CSA_ASSERT(a_stop_pair, push.v1 |-> (push.r0.port == PORT_STOP && !push.r0.last && push.r1.last), "stop results malformed")
  `CSA_ASSERT(a_stop_restart, push.v1 |=> (stop_seen && stop_age == '0), "stop did not restart the hold")
  `CSA_ASSERT(a_auto_gated, (push.v0 && item.opcode == OP_AUTO) |-> (auto_enabled && !hold_active), "autonomous item passed a closed gate")

endmodule

// File: sv/csa_queue.sv
// ----------------------------------------------------------------------------
// Command source arbiter result queue
// Small register queue that takes up to two results a cycle and hands one
// result a cycle to the output stream while the output is ready.
// ----------------------------------------------------------------------------
`include "command_source_arbiter_defines.svh"

module csa_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  csa_pkg::push_t              push,
  input  logic                        pop,
  output csa_pkg::res_t               head,
  output logic [csa_pkg::Q_PTR_W:0]   level
);
  import csa_pkg::*;

  res_t                 mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_PTR_W:0]     level_next;
  logic                 do_pop;

  assign do_pop = pop && (level != '0);
  assign head   = mem[rd_ptr];

  always_comb begin
    level_next = level;
    if (push.v0) level_next = level_next + 1'b1;
    if (push.v1) level_next = level_next + 1'b1;
    if (do_pop)  level_next = level_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem[wr_ptr] <= push.r0;
    if (push.v1) mem[wr_ptr + 1'b1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.v1) wr_ptr <= wr_ptr + 2'd2;
      else if (push.v0) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      level <= level_next;
    end
  end

  `CSA_ASSERT(a_no_overflow, level <= (Q_PTR_W+1)'(Q_DEPTH), "result queue overflow")
  `CSA_ASSERT(a_push_room, push.v0 |-> level <= (Q_PTR_W+1)'(Q_DEPTH - 2), "push without room")
  `CSA_ASSERT_ALWAYS(a_reset_empty, rst |=> level == '0, "queue not empty after reset")

endmodule

// File: sv/command_source_arbiter.sv
// An accepted item is registered in the input stage; the core's results for it are
// written into the result queue, whose head drives the output stream.
// Throughput: one item per cycle; a stop yields two results, drained one per cycle
// by the eight-entry queue while m_tready is high; input ready drops as it fills.
// Reset (synchronous, active high) restores the default registers, clears all
// mode and age state and empties the input stage and the result queue.
// ----------------------------------------------------------------------------
// Command source arbiter
// Priority command multiplexer with stop hold, manual override and watchdog.
// ----------------------------------------------------------------------------
module command_source_arbiter #(
  parameter int AGE_BITS = csa_pkg::AGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [csa_pkg::IDX_W-1:0]   cfg_index,
  input  logic [csa_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [71:0]                 s_tdata,   // auto_on, payload[63:0], zero fill
  input  logic [4:0]                  s_tuser,   // opcode[2:0], channel[1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,   // command[63:0]
  output logic [1:0]                  m_tuser,   // port[1:0]
  output logic                        m_tlast
);
  import csa_pkg::*;

  logic                 item_valid;
  item_t                item;
  push_t                push;
  res_t                 head;
  logic [Q_PTR_W:0]     level;
  logic [Q_PTR_W+1:0]   committed;

  // Results already queued plus the worst case of the item in the input stage.
  assign committed = (Q_PTR_W+2)'(level) + (item_valid ? (Q_PTR_W+2)'(2) : '0);
  assign s_tready  = committed <= (Q_PTR_W+2)'(Q_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.opcode  <= s_tuser[OP_W-1:0];
      item.channel <= s_tuser[OP_W+PORT_W-1:OP_W];
      item.auto_on <= s_tdata[0];
      item.payload <= s_tdata[CMD_W:1];
    end
  end

  csa_core #(
    .AGE_BITS(AGE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .push       (push)
  );

  csa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (m_tready),
    .head  (head),
    .level (level)
  );

  assign m_tvalid = level != '0;
  assign m_tdata  = head.command;
  assign m_tuser  = head.port;
  assign m_tlast  = head.last;

endmodule

// File: dv/arbiter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command source arbiter checker
// Watches the configuration port and both streams of the arbiter, keeps its
// own copy of the registers, mode and age state, works out the commands that
// each accepted item must produce and compares them in order with the items
// that leave the block.
// ----------------------------------------------------------------------------
module arbiter_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [csa_pkg::IDX_W-1:0]  cfg_index,
  input  logic [csa_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [71:0]                s_tdata,
  input  logic [4:0]                 s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [63:0]                m_tdata,
  input  logic [1:0]                 m_tuser,
  input  logic                       m_tlast,
  output int                         fail_count,
  output int                         outstanding
);
  import csa_pkg::*;

  localparam logic [AGE_BITS_DEF-1:0] AGE_TOP = '1;

  logic [CFG_W-1:0]        override_lim;
  logic [CFG_W-1:0]        failsafe_lim;
  logic [CFG_W-1:0]        hold_lim;
  logic [CFG_W-1:0]        period_lim;
  logic                    auto_en;
  logic                    stop_seen;
  logic                    manual_seen;
  logic                    valid_seen;
  logic [AGE_BITS_DEF-1:0] stop_age;
  logic [AGE_BITS_DEF-1:0] manual_age;
  logic [AGE_BITS_DEF-1:0] valid_age;
  logic [CFG_W-1:0]        check_phase;
  res_t                    due_cmds[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [AGE_BITS_DEF-1:0] bump(input logic [AGE_BITS_DEF-1:0] a);
    return (a == AGE_TOP) ? a : a + 1'b1;
  endfunction

  function automatic res_t make_cmd(input logic [PORT_W-1:0] port, input logic [CMD_W-1:0] cmd,
                                    input logic last);
    res_t r;
    r.port    = port;
    r.command = cmd;
    r.last    = last;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [CMD_W-1:0] want,
                               input logic [CMD_W-1:0] got);
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    fail_count++;
  endtask

  // Updates the state for one event and queues the commands it must produce.
  task automatic arbitrate(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] ch,
                           input logic aon, input logic [CMD_W-1:0] payload);
    logic holding;
    logic overriding;
    holding    = stop_seen && (stop_age < hold_lim);
    overriding = manual_seen && (manual_age < override_lim);
    case (op)
      OP_TICK: begin
        if (stop_seen) stop_age = bump(stop_age);
        if (manual_seen) manual_age = bump(manual_age);
        if (valid_seen) valid_age = bump(valid_age);
        check_phase = check_phase + 1'b1;
        if (check_phase >= period_lim) begin
          check_phase = '0;
          if (valid_seen && (valid_age > failsafe_lim))
            due_cmds.push_back(make_cmd(PORT_DRIVE, '0, 1'b1));
        end
      end
      OP_MODE: begin
        auto_en = aon;
      end
      OP_STOP: begin
        stop_seen = 1'b1;
        stop_age  = '0;
        due_cmds.push_back(make_cmd(PORT_STOP, payload, 1'b0));
        due_cmds.push_back(make_cmd(PORT_DRIVE, '0, 1'b1));
      end
      OP_MANUAL: begin
        if (ch != CH_INVALID) begin
          manual_seen = 1'b1;
          manual_age  = '0;
          valid_seen  = 1'b1;
          valid_age   = '0;
          if (!holding) due_cmds.push_back(make_cmd(ch, payload, 1'b1));
        end
      end
      OP_AUTO: begin
        if (ch != CH_INVALID && !holding && !overriding && auto_en) begin
          valid_seen = 1'b1;
          valid_age  = '0;
          due_cmds.push_back(make_cmd(ch, payload, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (rst) begin
      override_lim = OVERRIDE_RST;
      failsafe_lim = FAILSAFE_RST;
      hold_lim     = HOLD_RST;
      period_lim   = PERIOD_RST;
      auto_en      = 1'b0;
      stop_seen    = 1'b0;
      manual_seen  = 1'b0;
      valid_seen   = 1'b0;
      stop_age     = '0;
      manual_age   = '0;
      valid_age    = '0;
      check_phase  = '0;
      due_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OVERRIDE: override_lim = cfg_data;
          REG_FAILSAFE: failsafe_lim = cfg_data;
          REG_HOLD:     hold_lim     = cfg_data;
          REG_PERIOD:   period_lim   = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = make_cmd(m_tuser, m_tdata, m_tlast);
        if (due_cmds.size() == 0) begin
          $display("%0t: unexpected command: expected none, actual port %0d command %h last %0b",
                   $time, got.port, got.command, got.last);
          fail_count++;
        end else begin
          want = due_cmds.pop_front();
          if (got.port !== want.port) flag_mismatch("port", want.port, got.port);
          if (got.command !== want.command) flag_mismatch("command", want.command, got.command);
          if (got.last !== want.last) flag_mismatch("last", want.last, got.last);
        end
      end
      if (s_tvalid && s_tready)
        arbitrate(s_tuser[2:0], s_tuser[4:3], s_tdata[0], s_tdata[64:1]);
    end
    outstanding = due_cmds.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command source arbiter testbench
// Drives events into the arbiter through its input stream and configuration
// port: a directed pass over every event kind and corner, a run of ticks with
// the watchdog checking on every tick, then randomized phases under several
// register settings, most with random stalls on both streams. A separate checker
// predicts and compares every command; this module only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import csa_pkg::*;

  localparam logic [PORT_W-1:0] CH_DRIVE = 2'd0;
  localparam logic [PORT_W-1:0] CH_TILT  = 2'd1;
  localparam logic [PORT_W-1:0] CH_LIFT  = 2'd2;
  localparam int PHASES      = 7;
  localparam int RANDOM_ROW  = 5;
  localparam int PHASE_ITEMS = 240;
  localparam int LONG_HOLD   = 120;
  localparam int TICK_RUN    = 40;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [71:0]       s_tdata;
  logic [4:0]        s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [63:0]       m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;
  int                fail_count;
  int                outstanding;
  bit                idle_on;
  bit                hold_req;

  // Register settings per phase: override, failsafe, stop hold, check period.
  logic [CFG_W-1:0] phase_regs [PHASES][4] = '{
    '{16'd1, 16'd1, 16'd1, 16'd1},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd4, 16'd9, 16'd6, 16'd3},
    '{16'd25, 16'd40, 16'd30, 16'd8},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd12, 16'd20, 16'd10, 16'd5}
  };

  always #5 clk = ~clk;

  command_source_arbiter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  arbiter_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic send_event(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] ch,
                            input logic aon, input logic [CMD_W-1:0] payload);
    s_tvalid <= 1'b1;
    s_tuser  <= {ch, op};
    s_tdata  <= {7'd0, payload, aon};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Stops offering items until every predicted command has left the block,
  // then idles the input so that the pipeline can settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] ovr, input logic [CFG_W-1:0] fs,
                          input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] period);
    reg_idx_t idx [4];
    logic [CFG_W-1:0] val [4];
    idx = '{REG_OVERRIDE, REG_FAILSAFE, REG_HOLD, REG_PERIOD};
    val = '{ovr, fs, hold, period};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CMD_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly ticks and commands so that holds, overrides and the watchdog all
  // come into play; a small share is ignored noise.
  task automatic random_event(output bit counted);
    int unsigned pick;
    logic [PORT_W-1:0] ch;
    logic aon;
    pick    = $urandom_range(0, 99);
    ch      = PORT_W'($urandom_range(0, 2));
    aon     = 1'($urandom_range(0, 1));
    counted = 1'b1;
    if (pick < 40) begin
      send_event(OP_TICK, ch, aon, pick_payload());
    end else if (pick < 47) begin
      send_event(OP_MODE, ch, $urandom_range(0, 3) != 0, pick_payload());
    end else if (pick < 53) begin
      send_event(OP_STOP, ch, aon, pick_payload());
    end else if (pick < 72) begin
      send_event(OP_MANUAL, ch, aon, pick_payload());
    end else if (pick < 96) begin
      send_event(OP_AUTO, ch, aon, pick_payload());
    end else begin
      counted = 1'b0;
      if ($urandom_range(0, 1) == 0)
        send_event(OP_W'($urandom_range(OP_AUTO + 1, (1 << OP_W) - 1)), ch, aon,
                   pick_payload());
      else
        send_event($urandom_range(0, 1) ? OP_MANUAL : OP_AUTO, CH_INVALID, aon,
                   pick_payload());
    end
  endtask

  task automatic run_phase(input int items);
    int done;
    bit counted;
    done = 0;
    while (done < items) begin
      sender_gap();
      random_event(counted);
      if (counted) done++;
    end
  endtask

  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_OVERRIDE;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every event kind and corner under the reset register values.
    send_event(OP_TICK, CH_DRIVE, 1'b0, '1);
    for (int op = OP_AUTO + 1; op < (1 << OP_W); op++)
      send_event(OP_W'(op), CH_INVALID, 1'b1, '1);
    send_event(OP_AUTO, CH_DRIVE, 1'b0, pick_payload());
    send_event(OP_MODE, CH_DRIVE, 1'b1, '0);
    send_event(OP_AUTO, CH_DRIVE, 1'b1, '1);
    send_event(OP_AUTO, CH_TILT, 1'b0, '0);
    send_event(OP_AUTO, CH_LIFT, 1'b1, {$urandom, $urandom});
    send_event(OP_AUTO, CH_INVALID, 1'b0, '1);
    send_event(OP_MANUAL, CH_DRIVE, 1'b0, '0);
    send_event(OP_MANUAL, CH_TILT, 1'b1, '1);
    send_event(OP_MANUAL, CH_LIFT, 1'b0, {$urandom, $urandom});
    send_event(OP_MANUAL, CH_INVALID, 1'b1, '1);
    send_event(OP_AUTO, CH_TILT, 1'b1, '1);
    send_event(OP_STOP, CH_DRIVE, 1'b1, '1);
    send_event(OP_MANUAL, CH_LIFT, 1'b0, '1);
    send_event(OP_AUTO, CH_DRIVE, 1'b1, '1);
    send_event(OP_STOP, CH_LIFT, 1'b0, '0);
    send_event(OP_TICK, CH_TILT, 1'b1, '0);
    send_event(OP_MODE, CH_DRIVE, 1'b0, '1);
    drain();

    // Run of ticks with the watchdog checking on every tick.
    idle_on = 1'b0;
    set_regs(16'd30, 16'd20, 16'd25, 16'd1);
    send_event(OP_MODE, CH_DRIVE, 1'b1, '0);
    send_event(OP_MANUAL, CH_DRIVE, 1'b0, {$urandom, $urandom});
    send_event(OP_STOP, CH_DRIVE, 1'b0, {$urandom, $urandom});
    repeat (TICK_RUN) send_event(OP_TICK, CH_DRIVE, 1'b0, '0);
    send_event(OP_AUTO, CH_LIFT, 1'b1, {$urandom, $urandom});
    send_event(OP_MANUAL, CH_TILT, 1'b0, {$urandom, $urandom});
    send_event(OP_AUTO, CH_LIFT, 1'b1, {$urandom, $urandom});
    repeat (3) send_event(OP_TICK, CH_DRIVE, 1'b0, '0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      idle_on = !(p == 3 || p == PHASES - 1);
      if (p == RANDOM_ROW)
        set_regs(CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 64)),
                 CFG_W'($urandom_range(1, 64)), CFG_W'($urandom_range(1, 16)));
      else
        set_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2], phase_regs[p][3]);
      if (p == 2) begin
        // The output holds off while stops keep arriving, so the result
        // queue fills and the input has to stall.
        hold_req = 1'b1;
        repeat (24) send_event(OP_STOP, PORT_W'($urandom_range(0, 2)), 1'b0, pick_payload());
      end
      run_phase(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("command_source_arbiter test passed");
    else
      $display("command_source_arbiter test failed");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("command_source_arbiter test failed");
    $finish;
  end

endmodule

// File: command_source_arbiter.f
+incdir+sv
sv/csa_pkg.sv
sv/csa_core.sv
sv/csa_queue.sv
sv/command_source_arbiter.sv
dv/arbiter_checker.sv
dv/tb_top.sv
